[hdl/ndcg_pkg.sv]
// shared constants, types and the discount table for the ndcg list scorer
// no dependencies
package ndcg_pkg;

  localparam int unsigned MAX_ITEMS = 256;
  localparam int unsigned IDX_W     = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned SCORE_W   = 32;
  localparam int unsigned REL_W     = 4;
  localparam int unsigned GAIN_W    = 15;
  localparam int unsigned DISC_W    = 17;
  localparam int unsigned ACC_W     = GAIN_W + DISC_W + CNT_W;
  localparam int unsigned ENTRY_W   = SCORE_W + REL_W;
  localparam int unsigned NDCG_W    = 17;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned QUO_W     = 16;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DROPPED = 2'd2;

  typedef logic [MAX_ITEMS-1:0][DISC_W-1:0] disc_tab_t;

  // 1 / log2(pos + 2) in q.16, rounded half up
  function automatic logic [DISC_W-1:0] disc_f(int unsigned pos);
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] lg;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    int unsigned e;
    m = 64'(pos) + 64'd2;
    e = 0;
    for (int b = 1; b < 32; b++) begin
      if ((m >> b) != 64'd0) e = b;
    end
    x  = m << (30 - e);
    lg = 64'(e) << 16;
    for (int i = 15; i >= 0; i--) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        x  = x >> 1;
        lg = lg | (64'd1 << i);
      end
    end
    num = (64'd1 << 32) + (lg >> 1);
    rem = 64'd0;
    quo = 64'd0;
    for (int b = 40; b >= 0; b--) begin
      rem = (rem << 1) | 64'(num[b]);
      if (rem >= lg) begin
        rem    = rem - lg;
        quo[b] = 1'b1;
      end
    end
    return quo[DISC_W-1:0];
  endfunction

  function automatic disc_tab_t build_disc_tab();
    disc_tab_t t;
    for (int p = 0; p < MAX_ITEMS; p++) begin
      t[p] = disc_f(p);
    end
    return t;
  endfunction

  localparam disc_tab_t DISC_TAB = build_disc_tab();

  function automatic logic [GAIN_W-1:0] gain_f(logic [REL_W-1:0] rel);
    return (GAIN_W'(1) << rel) - GAIN_W'(1);
  endfunction

endpackage

[hdl/ndcg_list_scorer.sv]
// ndcg at k list scorer: loads a list into ram, ranks it, emits q1.16 ndcg
// depends on ndcg_pkg and ndcg_ram
//
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   predicted_score, true_relevance, last_item
// out      output     out_valid_o / out_stall_i ndcg_value, status, items_used
// cfg      input      cfg_we_i                  cfg_wdata_i (cutoff_count)
//
// loading accepts one item per cycle, one ram write each; items past MAX_ITEMS are dropped
// scoring sums the ideal gain from the relevance histogram, then runs one selection scan
// over the ram read port per ranked position, then the division
// in_stall_o is high from the last-item transfer until the result is registered
// reset clears counters, histogram and handshake state; ram contents are not cleared
module ndcg_list_scorer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [ndcg_pkg::SCORE_W-1:0] predicted_score_i,
  input  logic [ndcg_pkg::REL_W-1:0]      true_relevance_i,
  input  logic                            last_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ndcg_pkg::NDCG_W-1:0]     ndcg_value_o,
  output logic [ndcg_pkg::STAT_W-1:0]     status_o,
  output logic [ndcg_pkg::CNT_W-1:0]      items_used_o,
  input  logic                            cfg_we_i,
  input  logic [ndcg_pkg::CNT_W-1:0]      cfg_wdata_i
);
  import ndcg_pkg::*;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_IDEAL = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_AMUL  = 3'd3;
  localparam logic [2:0] ST_DWAIT = 3'd4;
  localparam logic [2:0] ST_DSET  = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       cutoff_q;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   ovf_q, ovf_d;
  logic [CNT_W-1:0]       hist_q [16];
  logic [CNT_W-1:0]       hist_d [16];
  logic [CNT_W-1:0]       n_q, n_d;
  logic [CNT_W-1:0]       pos_q, pos_d;
  logic [REL_W-1:0]       rel_q, rel_d;
  logic [CNT_W-1:0]       j_q, j_d;
  logic [ACC_W-1:0]       ideal_q, ideal_d;
  logic [ACC_W-1:0]       actual_q, actual_d;
  logic [GAIN_W+DISC_W-1:0] prod_q, prod_d;
  logic                   pend_q, pend_d;
  logic                   tgt_act_q, tgt_act_d;
  logic [CNT_W-1:0]       issue_q, issue_d;
  logic                   rvld_q, rvld_d;
  logic [IDX_W-1:0]       ridx_q, ridx_d;
  logic                   best_v_q, best_v_d;
  logic [ENTRY_W-1:0]     best_key_q, best_key_d;
  logic [IDX_W-1:0]       best_idx_q, best_idx_d;
  logic [ENTRY_W+IDX_W-1:0] prev_sel_q, prev_sel_d;
  logic [ACC_W:0]         rem_q, rem_d;
  logic [QUO_W-1:0]       quo_q, quo_d;
  logic [3:0]             it_q, it_d;
  logic                   sat_q, sat_d;
  logic                   out_valid_q, out_valid_d;
  logic [NDCG_W-1:0]      ndcg_q, ndcg_d;
  logic [STAT_W-1:0]      status_q, status_d;
  logic [CNT_W-1:0]       used_n_q, used_n_d;

  logic                   in_xfer;
  logic                   ram_we;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [ENTRY_W-1:0]     rd_key;
  logic [ENTRY_W+IDX_W-1:0] rd_sel;
  logic [ENTRY_W+IDX_W-1:0] best_sel;
  logic [ACC_W:0]         rem_sh;
  logic [REL_W-1:0]       best_rel;

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign ram_we     = in_xfer && (count_q < CNT_W'(MAX_ITEMS));
  assign ram_wdata  = {predicted_score_i ^ {1'b1, {(SCORE_W-1){1'b0}}}, true_relevance_i};
  assign rd_key     = {ram_rdata[ENTRY_W-1:REL_W], ~ram_rdata[REL_W-1:0]};
  // rank key with the lower index first among equal keys
  assign rd_sel     = {rd_key, ~ridx_q};
  assign best_sel   = {best_key_q, ~best_idx_q};
  assign best_rel   = ~best_key_q[REL_W-1:0];
  assign rem_sh     = {rem_q[ACC_W-1:0], 1'b0};

  ndcg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (issue_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    hist_d      = hist_q;
    n_d         = n_q;
    pos_d       = pos_q;
    rel_d       = rel_q;
    j_d         = j_q;
    ideal_d     = ideal_q;
    actual_d    = actual_q;
    prod_d      = prod_q;
    pend_d      = 1'b0;
    tgt_act_d   = tgt_act_q;
    issue_d     = issue_q;
    rvld_d      = 1'b0;
    ridx_d      = issue_q[IDX_W-1:0];
    best_v_d    = best_v_q;
    best_key_d  = best_key_q;
    best_idx_d  = best_idx_q;
    prev_sel_d  = prev_sel_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    it_d        = it_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q && out_stall_i;
    ndcg_d      = ndcg_q;
    status_d    = status_q;
    used_n_d    = used_n_q;

    if (pend_q) begin
      if (tgt_act_q) actual_d = actual_q + ACC_W'(prod_q);
      else           ideal_d  = ideal_q + ACC_W'(prod_q);
    end

    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          if (ram_we) begin
            count_d = count_q + CNT_W'(1);
            hist_d[true_relevance_i] = hist_q[true_relevance_i] + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_item_i) begin
            n_d = (cutoff_q == '0 || cutoff_q > count_d) ? count_d : cutoff_q;
            pos_d     = '0;
            rel_d     = '1;
            j_d       = '0;
            ideal_d   = '0;
            actual_d  = '0;
            tgt_act_d = 1'b0;
            state_d   = ST_IDEAL;
          end
        end
      end
      ST_IDEAL: begin
        if (pos_q == n_q) begin
          pos_d     = '0;
          issue_d   = '0;
          best_v_d  = 1'b0;
          state_d   = ST_SCAN;
        end else if (j_q == hist_q[rel_q]) begin
          rel_d = rel_q - REL_W'(1);
          j_d   = '0;
        end else begin
          prod_d    = gain_f(rel_q) * DISC_TAB[pos_q[IDX_W-1:0]];
          pend_d    = 1'b1;
          tgt_act_d = 1'b0;
          j_d       = j_q + CNT_W'(1);
          pos_d     = pos_q + CNT_W'(1);
        end
      end
      ST_SCAN: begin
        if (issue_q < count_q) begin
          rvld_d  = 1'b1;
          issue_d = issue_q + CNT_W'(1);
        end
        if (rvld_q) begin
          // only entries ranked below the previous pick are candidates
          if ((pos_q == '0 || rd_sel < prev_sel_q) && (!best_v_q || rd_sel > best_sel)) begin
            best_v_d   = 1'b1;
            best_key_d = rd_key;
            best_idx_d = ridx_q;
          end
          if (CNT_W'(ridx_q) == count_q - CNT_W'(1)) state_d = ST_AMUL;
        end
      end
      ST_AMUL: begin
        prod_d             = gain_f(best_rel) * DISC_TAB[pos_q[IDX_W-1:0]];
        pend_d             = 1'b1;
        tgt_act_d          = 1'b1;
        prev_sel_d         = best_sel;
        pos_d              = pos_q + CNT_W'(1);
        issue_d            = '0;
        best_v_d           = 1'b0;
        state_d            = (pos_d == n_q) ? ST_DWAIT : ST_SCAN;
      end
      ST_DWAIT: begin
        state_d = ST_DSET;
      end
      ST_DSET: begin
        rem_d   = {1'b0, actual_q};
        quo_d   = '0;
        it_d    = '0;
        sat_d   = (actual_q >= ideal_q);
        state_d = (ideal_q == '0 || actual_q >= ideal_q) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, ideal_q}) begin
          rem_d = rem_sh - {1'b0, ideal_q};
          quo_d = {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[QUO_W-2:0], 1'b0};
        end
        it_d = it_q + 4'd1;
        if (it_q == 4'd15) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          used_n_d    = n_q;
          if (ideal_q == '0) ndcg_d = '0;
          else if (sat_q)    ndcg_d = NDCG_W'(1) << QUO_W;
          else               ndcg_d = NDCG_W'(quo_q);
          if (ovf_q)               status_d = STAT_DROPPED;
          else if (ideal_q == '0)  status_d = STAT_ZERO;
          else                     status_d = STAT_OK;
          count_d = '0;
          ovf_d   = 1'b0;
          for (int r = 0; r < 16; r++) hist_d[r] = '0;
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cutoff_q    <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      for (int r = 0; r < 16; r++) hist_q[r] <= '0;
      pend_q      <= 1'b0;
      rvld_q      <= 1'b0;
      best_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      pos_q       <= '0;
      issue_q     <= '0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) cutoff_q <= cfg_wdata_i;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      hist_q      <= hist_d;
      pend_q      <= pend_d;
      rvld_q      <= rvld_d;
      best_v_q    <= best_v_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      pos_q       <= pos_d;
      issue_q     <= issue_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rel_q      <= rel_d;
    j_q        <= j_d;
    ideal_q    <= ideal_d;
    actual_q   <= actual_d;
    prod_q     <= prod_d;
    tgt_act_q  <= tgt_act_d;
    ridx_q     <= ridx_d;
    best_key_q <= best_key_d;
    best_idx_q <= best_idx_d;
    prev_sel_q <= prev_sel_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    it_q       <= it_d;
    sat_q      <= sat_d;
    ndcg_q     <= ndcg_d;
    status_q   <= status_d;
    used_n_q   <= used_n_d;
  end

  assign out_valid_o  = out_valid_q;
  assign ndcg_value_o = ndcg_q;
  assign status_o     = status_q;
  assign items_used_o = used_n_q;

  a_ndcg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ndcg_value_o <= (NDCG_W'(1) << QUO_W))
    else $error("ndcg value above 1.0");

  a_zero_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_ZERO) |-> ndcg_value_o == '0)
    else $error("zero ideal gain with nonzero value");

  a_used_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> items_used_o != '0)
    else $error("result with no positions");

  a_scan_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_AMUL) |-> pos_q < n_q)
    else $error("selection past cutoff");

  a_actual_le_ideal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DSET) |-> actual_q <= ideal_q)
    else $error("actual gain above ideal gain");

endmodule

[hdl/ndcg_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module ndcg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[test/ndcg_list_scorer_test.sv]
// self-checking bench for ndcg_list_scorer: random and directed lists, ndcg at k predicted
// in the bench and compared per field; depends on ndcg_pkg and the scorer rtl
`timescale 1ns / 1ps
module ndcg_list_scorer_test;
  import ndcg_pkg::*;

  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic [REL_W-1:0]          rel;
    logic                      last;
  } list_item_t;

  typedef struct {
    logic [NDCG_W-1:0] ndcg;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  used;
  } ndcg_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [SCORE_W-1:0] predicted_score_i = '0;
  logic [REL_W-1:0] true_relevance_i = '0;
  logic last_item_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [NDCG_W-1:0] ndcg_value_o;
  logic [STAT_W-1:0] status_o;
  logic [CNT_W-1:0] items_used_o;
  logic cfg_we_i = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;

  ndcg_list_scorer dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .predicted_score_i, .true_relevance_i,
    .last_item_i, .out_valid_o, .out_stall_i, .ndcg_value_o, .status_o, .items_used_o,
    .cfg_we_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  list_item_t pending_items[$];
  ndcg_result_t expected_scores[$];
  longint unsigned disc_q16[MAX_ITEMS];
  logic signed [SCORE_W-1:0] list_score[MAX_ITEMS];
  logic [REL_W-1:0] list_rel[MAX_ITEMS];
  int unsigned list_len = 0;
  bit list_dropped = 1'b0;
  int unsigned cutoff = 0;
  int errors = 0;
  int items_queued = 0;
  int lists_scored = 0;
  int drop_lists = 0;
  int zero_lists = 0;
  bit in_taken = 1'b0;
  bit calm = 1'b0;
  int idle_left = 0;
  int stall_left = 0;
  int long_hold = 0;

  function automatic longint unsigned calc_discount(int unsigned pos);
    longint unsigned m, x, lg;
    int unsigned e;
    m = pos + 2;
    e = 0;
    while ((m >> (e + 1)) != 0) e++;
    x = m << (30 - e);
    lg = longint'(e) << 16;
    for (int i = 15; i >= 0; i--) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        lg = lg | (64'd1 << i);
      end
    end
    return ((64'd1 << 32) + (lg >> 1)) / lg;
  endfunction

  function automatic ndcg_result_t score_list();
    ndcg_result_t r;
    int unsigned n, pos, k, t;
    int unsigned order[MAX_ITEMS];
    int unsigned hist[16];
    longint unsigned ideal, actual, ratio;
    ideal = 0;
    actual = 0;
    n = (cutoff == 0 || cutoff > list_len) ? list_len : cutoff;
    for (int g = 0; g < 16; g++) hist[g] = 0;
    for (int i = 0; i < list_len; i++) hist[list_rel[i]]++;
    pos = 0;
    for (int g = 15; g >= 0; g--) begin
      for (int j = 0; j < hist[g]; j++) begin
        if (pos < n) ideal += ((64'd1 << g) - 1) * disc_q16[pos];
        pos++;
      end
    end
    // stable insertion sort: score descending, then relevance ascending
    for (int i = 0; i < list_len; i++) begin
      k = i;
      while (k > 0) begin
        t = order[k-1];
        if (list_score[i] > list_score[t] ||
            (list_score[i] == list_score[t] && list_rel[i] < list_rel[t])) begin
          order[k] = t;
          k--;
        end else break;
      end
      order[k] = i;
    end
    for (int p = 0; p < n; p++) actual += ((64'd1 << list_rel[order[p]]) - 1) * disc_q16[p];
    if (ideal == 0) begin
      r.ndcg = '0;
      r.status = STAT_ZERO;
      zero_lists++;
    end else begin
      ratio = (actual << 16) / ideal;
      if (ratio > 65536) ratio = 65536;
      r.ndcg = NDCG_W'(ratio);
      r.status = STAT_OK;
    end
    if (list_dropped) begin
      r.status = STAT_DROPPED;
      drop_lists++;
    end
    r.used = CNT_W'(n);
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // input transfers feed the predictor, output transfers are checked
  always @(posedge clk_i) begin
    ndcg_result_t want;
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (list_len < MAX_ITEMS) begin
        list_score[list_len] = predicted_score_i;
        list_rel[list_len] = true_relevance_i;
        list_len++;
      end else list_dropped = 1'b1;
      if (last_item_i) begin
        expected_scores.push_back(score_list());
        list_len = 0;
        list_dropped = 1'b0;
      end
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_scores.size() == 0) report("unexpected result", ndcg_value_o, 0);
      else begin
        want = expected_scores.pop_front();
        lists_scored++;
        if (ndcg_value_o !== want.ndcg) report("ndcg_value", ndcg_value_o, want.ndcg);
        if (status_o !== want.status) report("status", status_o, want.status);
        if (items_used_o !== want.used) report("items_used", items_used_o, want.used);
      end
    end
  end

  always @(negedge clk_i) begin
    list_item_t it;
    if (!in_valid_i || in_taken) begin
      if (idle_left > 0) begin
        in_valid_i <= 1'b0;
        idle_left--;
      end else if (pending_items.size() > 0 && rst_ni) begin
        it = pending_items.pop_front();
        predicted_score_i <= it.score;
        true_relevance_i <= it.rel;
        last_item_i <= it.last;
        in_valid_i <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) idle_left = $urandom_range(1, 6);
      end else in_valid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (long_hold > 0) begin
      out_stall_i <= 1'b1;
      long_hold--;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(1, 6) - 1;
    end else out_stall_i <= 1'b0;
  end

  task automatic push_item(input logic signed [SCORE_W-1:0] s, input logic [REL_W-1:0] r,
                           input logic l);
    list_item_t it;
    it.score = s;
    it.rel = r;
    it.last = l;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_list(input int len, input int score_mode, input int rel_mode);
    logic signed [SCORE_W-1:0] s;
    logic [REL_W-1:0] r;
    for (int i = 0; i < len; i++) begin
      case (score_mode)
        0: s = $urandom;
        1: s = $signed($urandom_range(0, 6)) - 3;
        default: case ($urandom_range(0, 3))
          0: s = 32'sh8000_0000;
          1: s = 32'sh7fff_ffff;
          2: s = 0;
          default: s = -1;
        endcase
      endcase
      case (rel_mode)
        0: r = $urandom_range(0, 15);
        1: r = 0;
        default: r = $urandom_range(0, 2);
      endcase
      push_item(s, r, i == len - 1);
    end
  endtask

  // wait until the bench is quiet: nothing queued, offered or outstanding
  task automatic wait_idle();
    int quiet;
    quiet = 0;
    while (quiet < 20) begin
      @(negedge clk_i);
      if (pending_items.size() != 0 || in_valid_i || expected_scores.size() != 0) quiet = 0;
      else quiet++;
    end
  endtask

  task automatic write_cutoff(input int unsigned v);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CNT_W'(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cutoff = v;
  endtask

  initial begin
    for (int p = 0; p < MAX_ITEMS; p++) disc_q16[p] = calc_discount(p);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed lists, starting at the reset cutoff value
    push_item(32'sh7fff_ffff, 4'd15, 1'b1);
    push_item(32'sh8000_0000, 4'd0, 1'b1);
    push_item(32'sh7fff_ffff, 4'd0, 1'b0);
    push_item(32'sh8000_0000, 4'd15, 1'b1);
    push_item(5, 4'd3, 1'b0);
    push_item(5, 4'd9, 1'b0);
    push_item(5, 4'd1, 1'b0);
    push_item(-7, 4'd15, 1'b1);
    push_item(0, 4'd0, 1'b0);
    push_item(-1, 4'd0, 1'b1);
    write_cutoff(1);
    push_item(1, 4'd2, 1'b0);
    push_item(2, 4'd8, 1'b1);
    push_item(1, 4'd0, 1'b0);
    push_item(2, 4'd0, 1'b0);
    push_item(3, 4'd7, 1'b1);
    write_cutoff(256);
    push_item(9, 4'd15, 1'b0);
    push_item(9, 4'd15, 1'b0);
    push_item(-9, 4'd14, 1'b1);
    write_cutoff(511);
    push_item(100, 4'd1, 1'b0);
    push_item(200, 4'd2, 1'b1);

    // full store: exact fit, dropped last mark, long overflow
    write_cutoff(0);
    push_list(256, 0, 0);
    push_list(257, 1, 2);
    write_cutoff(256);
    push_list(300, 0, 1);
    write_cutoff(3);
    push_list(258, 2, 0);

    // receiver holds off long while lists keep coming
    wait_idle();
    long_hold = 400;
    for (int i = 0; i < 8; i++) push_list($urandom_range(1, 10), 0, 0);

    // sender pauses until all results are back
    wait_idle();
    while (items_queued < 1400) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 5))
          0: write_cutoff(0);
          1: write_cutoff(1);
          2: write_cutoff(256);
          3: write_cutoff(255);
          default: write_cutoff($urandom_range(0, 20));
        endcase
      end
      if (items_queued > 1250) calm = 1'b1;
      push_list($urandom_range(1, 16), $urandom_range(0, 2),
                ($urandom_range(0, 5) == 0) ? 1 : (($urandom_range(0, 3) == 0) ? 2 : 0));
      if (pending_items.size() > 60) wait (pending_items.size() < 20);
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    $display("covered %0d items in %0d scored lists, %0d with dropped items, %0d with zero ideal",
             items_queued, lists_scored, drop_lists, zero_lists);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("timeout with %0d results outstanding", expected_scores.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
hdl/ndcg_pkg.sv
hdl/ndcg_ram.sv
hdl/ndcg_list_scorer.sv
test/ndcg_list_scorer_test.sv
